FILE: rtl/core/planar_pixel_mask_plotter_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the planar pixel mask plotter
// Shared wrappers that clock and report concurrent checks; one reset-qualifies.
// ----------------------------------------------------------------------------
`ifndef PLANAR_PIXEL_MASK_PLOTTER_CORE_ASSERT_SVH
`define PLANAR_PIXEL_MASK_PLOTTER_CORE_ASSERT_SVH

// Check that is switched off while the active-low reset is asserted.
`define PPMP_ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check that is evaluated at every rising clock edge, reset included.
`define PPMP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/ppmp_pkg.sv
// ----------------------------------------------------------------------------
// Planar pixel mask plotter package
// Field widths, codes, sequencer states and default screen geometry.
// ----------------------------------------------------------------------------
package ppmp_pkg;

    localparam int DEF_SCREEN_WIDTH  = 320;
    localparam int DEF_SCREEN_HEIGHT = 200;

    localparam int PIX_W      = 4;
    localparam int COORD_W    = 10;
    localparam int ACTION_W   = 2;
    localparam int PATTERN_W  = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PLOT  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_CLEAR = 2'd2
    } ppmp_action_t;

    typedef enum logic [PATTERN_W-1:0] {
        PAT_SINGLE = 2'd0,
        PAT_PAIR   = 2'd1
    } ppmp_pattern_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE     = 2'd0,
        STATUS_SKIPPED  = 2'd1,
        STATUS_REJECTED = 2'd2
    } ppmp_status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DRAW_MODE    = 2'd0,
        CFG_PLANE_ENABLE = 2'd1,
        CFG_XOR_MASK     = 2'd2,
        CFG_XOR_ON       = 2'd3
    } ppmp_cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_RD,
        ST_MOD,
        ST_CLEAR,
        ST_DONE
    } ppmp_state_t;

    localparam logic [PIX_W-1:0] XOR_MODE = 4'd1;

endpackage

FILE: rtl/core/ppmp_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One address per cycle, write when enabled, read data registered.
// ----------------------------------------------------------------------------
module ppmp_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64000
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: rtl/core/planar_pixel_mask_plotter_core.sv
// ----------------------------------------------------------------------------
// Planar pixel mask plotter core
// Plots, reads and clears a 4-bit indexed frame store through one RAM port.
// ----------------------------------------------------------------------------
// The block takes one item at a time and drops s_tready until that item's
// result has been placed in the output register; a new item may be accepted
// while that result still waits for its transfer. Each touched pixel is a
// read-modify-write on the single frame store port, states ST_RD then ST_MOD,
// and the pixels of one item are handled one after another: a plot touches
// one pixel, or up to four for the two-row pair; a read touches one. A clear
// writes the SCREEN_WIDTH * SCREEN_HEIGHT entries, one entry per cycle. The
// frame store holds no defined content after reset until a clear item has
// run; there is no clearing pass at reset.
// ----------------------------------------------------------------------------
module planar_pixel_mask_plotter_core #(
    parameter int SCREEN_WIDTH  = ppmp_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = ppmp_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration write port.
    input  logic                             cfg_wr_en,
    input  logic [ppmp_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [ppmp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // Input stream.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // Fields from bit 0: px_x[9:0], px_y[19:10], pattern[21:20], zero fill.
    input  logic [ppmp_pkg::S_TDATA_W-1:0]   s_tdata,
    // Fields from bit 0: action[1:0].
    input  logic [ppmp_pkg::ACTION_W-1:0]    s_tuser,
    // Result stream.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // Fields from bit 0: pixel_value[3:0], zero fill.
    output logic [ppmp_pkg::M_TDATA_W-1:0]   m_tdata,
    // Fields from bit 0: status[1:0].
    output logic [ppmp_pkg::STATUS_W-1:0]    m_tuser
);

    import ppmp_pkg::*;

    localparam int STORE_SIZE = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W     = $clog2(STORE_SIZE);

    localparam logic signed [11:0] WIDTH_S   = 12'(SCREEN_WIDTH);
    localparam logic signed [11:0] HEIGHT_S  = 12'(SCREEN_HEIGHT);
    localparam logic [11:0]        WIDTH_U   = 12'(SCREEN_WIDTH);
    localparam logic [ADDR_W-1:0]  WIDTH_A   = ADDR_W'(SCREEN_WIDTH);
    localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(STORE_SIZE - 1);

    // Configuration registers.
    logic [PIX_W-1:0] draw_mode_reg;
    logic [PIX_W-1:0] plane_en_reg;
    logic [PIX_W-1:0] xor_mask_reg;
    logic             xor_on_reg;

    // Control state.
    ppmp_state_t      state_reg, state_next;
    logic             m_valid_reg, m_valid_next;

    // Item payload.
    logic [COORD_W-1:0]  c0_reg, c0_next;
    logic [COORD_W-1:0]  y_reg, y_next;
    logic                is_read_reg, is_read_next;
    logic                two_col_reg, two_col_next;
    logic                two_row_reg, two_row_next;
    logic                op_xor_reg, op_xor_next;
    logic [PIX_W-1:0]    op_val_reg, op_val_next;
    logic [PIX_W-1:0]    target_reg, target_next;
    logic                col_k_reg, col_k_next;
    logic                row_k_reg, row_k_next;
    logic [ADDR_W-1:0]   row_addr_reg, row_addr_next;
    logic [ADDR_W-1:0]   clr_addr_reg, clr_addr_next;
    ppmp_status_t        status_reg, status_next;
    logic [PIX_W-1:0]    value_reg, value_next;
    ppmp_status_t        m_status_reg, m_status_next;
    logic [PIX_W-1:0]    m_value_reg, m_value_next;

    // Input field views.
    logic [COORD_W-1:0]   in_x;
    logic [COORD_W-1:0]   in_y;
    logic [PATTERN_W-1:0] in_pattern;
    logic signed [11:0]   x_e;
    logic signed [11:0]   y_e;
    logic signed [11:0]   rows_e;
    logic                 x_bad;
    logic                 plot_rej;
    logic                 read_bad;
    logic                 is_pair;
    logic                 override_on;
    logic [COORD_W-1:0]   c0_sel;

    // Frame store port.
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_addr;
    logic [PIX_W-1:0]     ram_wdata;
    logic [PIX_W-1:0]     ram_rdata;
    logic [ADDR_W-1:0]    pix_addr;
    logic [PIX_W-1:0]     new_pix;
    logic                 out_free;

    assign in_x       = s_tdata[9:0];
    assign in_y       = s_tdata[19:10];
    assign in_pattern = s_tdata[21:20];

    assign x_e    = {{2{in_x[COORD_W-1]}}, in_x};
    assign y_e    = {{2{in_y[COORD_W-1]}}, in_y};
    assign is_pair = (in_pattern == PAT_PAIR);
    assign rows_e = is_pair ? 12'sd2 : 12'sd1;

    assign x_bad    = (x_e < 12'sd0) || (x_e >= WIDTH_S);
    assign plot_rej = in_pattern[1] || x_bad || (y_e >= HEIGHT_S) ||
                      ((y_e + rows_e) > HEIGHT_S);
    assign read_bad = x_bad || (y_e < 12'sd0) || (y_e >= HEIGHT_S);

    assign override_on = xor_on_reg && (xor_mask_reg != '0);

    assign c0_sel = (s_tuser == ACT_PLOT && is_pair && in_x[3:0] != 4'd0)
                    ? in_x - COORD_W'(1) : in_x;

    assign pix_addr = row_addr_reg + ADDR_W'(col_k_reg);
    assign new_pix  = op_xor_reg ? (ram_rdata ^ op_val_reg)
                                 : ((ram_rdata & ~plane_en_reg) | (target_reg & plane_en_reg));
    assign out_free = !m_valid_reg || m_tready;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - PIX_W){1'b0}}, m_value_reg};
    assign m_tuser  = m_status_reg;

    always_comb begin
        state_next    = state_reg;
        m_valid_next  = m_valid_reg;
        c0_next       = c0_reg;
        y_next        = y_reg;
        is_read_next  = is_read_reg;
        two_col_next  = two_col_reg;
        two_row_next  = two_row_reg;
        op_xor_next   = op_xor_reg;
        op_val_next   = op_val_reg;
        target_next   = target_reg;
        col_k_next    = col_k_reg;
        row_k_next    = row_k_reg;
        row_addr_next = row_addr_reg;
        clr_addr_next = clr_addr_reg;
        status_next   = status_reg;
        value_next    = value_reg;
        m_status_next = m_status_reg;
        m_value_next  = m_value_reg;
        ram_we        = 1'b0;
        ram_addr      = pix_addr;
        ram_wdata     = new_pix;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    c0_next      = c0_sel;
                    y_next       = in_y;
                    value_next   = '0;
                    status_next  = STATUS_DONE;
                    is_read_next = 1'b0;
                    two_col_next = is_pair &&
                                   (({2'b00, c0_sel} + 12'd1) < WIDTH_U);
                    two_row_next = is_pair && !override_on;
                    op_xor_next  = override_on ||
                                   (!is_pair && draw_mode_reg == XOR_MODE);
                    op_val_next  = override_on ? (xor_mask_reg & plane_en_reg)
                                               : plane_en_reg;
                    target_next  = (!is_pair && draw_mode_reg > XOR_MODE)
                                   ? draw_mode_reg - XOR_MODE : draw_mode_reg;
                    unique case (s_tuser)
                        ACT_PLOT: begin
                            if (plot_rej) begin
                                status_next = STATUS_REJECTED;
                                state_next  = ST_DONE;
                            end else if (y_e <= 12'sd0) begin
                                status_next = STATUS_SKIPPED;
                                state_next  = ST_DONE;
                            end else begin
                                state_next  = ST_CALC;
                            end
                        end
                        ACT_READ: begin
                            is_read_next = 1'b1;
                            two_col_next = 1'b0;
                            two_row_next = 1'b0;
                            if (read_bad) begin
                                status_next = STATUS_REJECTED;
                                state_next  = ST_DONE;
                            end else begin
                                state_next  = ST_CALC;
                            end
                        end
                        ACT_CLEAR: begin
                            clr_addr_next = '0;
                            state_next    = ST_CLEAR;
                        end
                        default: begin
                            status_next = STATUS_REJECTED;
                            state_next  = ST_DONE;
                        end
                    endcase
                end
            end
            ST_CALC: begin
                row_addr_next = ADDR_W'(y_reg) * WIDTH_A + ADDR_W'(c0_reg);
                col_k_next    = 1'b0;
                row_k_next    = 1'b0;
                state_next    = ST_RD;
            end
            ST_RD: begin
                state_next = ST_MOD;
            end
            ST_MOD: begin
                if (is_read_reg) begin
                    value_next = ram_rdata;
                    state_next = ST_DONE;
                end else begin
                    ram_we = 1'b1;
                    priority if (!col_k_reg && two_col_reg) begin
                        col_k_next = 1'b1;
                        state_next = ST_RD;
                    end else if (!row_k_reg && two_row_reg) begin
                        col_k_next    = 1'b0;
                        row_k_next    = 1'b1;
                        row_addr_next = row_addr_reg + WIDTH_A;
                        state_next    = ST_RD;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = clr_addr_reg;
                ram_wdata = '0;
                if (clr_addr_reg == LAST_ADDR) begin
                    state_next = ST_DONE;
                end else begin
                    clr_addr_next = clr_addr_reg + ADDR_W'(1);
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_value_next  = value_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            draw_mode_reg <= 4'd0;
            plane_en_reg  <= 4'd15;
            xor_mask_reg  <= 4'd0;
            xor_on_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_DRAW_MODE:    draw_mode_reg <= cfg_wdata;
                    CFG_PLANE_ENABLE: plane_en_reg  <= cfg_wdata;
                    CFG_XOR_MASK:     xor_mask_reg  <= cfg_wdata;
                    CFG_XOR_ON:       xor_on_reg    <= cfg_wdata[0];
                    default:          xor_on_reg    <= xor_on_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        c0_reg       <= c0_next;
        y_reg        <= y_next;
        is_read_reg  <= is_read_next;
        two_col_reg  <= two_col_next;
        two_row_reg  <= two_row_next;
        op_xor_reg   <= op_xor_next;
        op_val_reg   <= op_val_next;
        target_reg   <= target_next;
        col_k_reg    <= col_k_next;
        row_k_reg    <= row_k_next;
        row_addr_reg <= row_addr_next;
        clr_addr_reg <= clr_addr_next;
        status_reg   <= status_next;
        value_reg    <= value_next;
        m_status_reg <= m_status_next;
        m_value_reg  <= m_value_next;
    end

    ppmp_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_SIZE)
    ) u_frame_store (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

endmodule

FILE: rtl/core/ppmp_checker.sv
// ----------------------------------------------------------------------------
// Planar pixel mask plotter port checker
// Watches the top-level stream ports and is bound to every core instance.
// ----------------------------------------------------------------------------
`include "planar_pixel_mask_plotter_core_assert.svh"

module ppmp_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [ppmp_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic [ppmp_pkg::STATUS_W-1:0]    m_tuser
);

    import ppmp_pkg::*;

    // No result is offered in the cycle after a reset edge.
    `PPMP_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

    // An accepted transfer always keeps the block busy for the next cycle.
    `PPMP_ASSERT_RST(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "ready held after accepted transfer")

    // A fresh result is only produced right after the block was busy, with s_tready low.
    `PPMP_ASSERT_RST(a_result_after_busy, aclk, aresetn, $rose(m_tvalid) |-> $past(!s_tready), "result appeared without busy cycle")

    // Only a completed read may carry a nonzero pixel value.
    `PPMP_ASSERT_RST(a_value_only_done, aclk, aresetn, m_tvalid && m_tuser != STATUS_DONE |-> m_tdata == '0, "pixel value on failed item")

    // A stalled result holds its payload.
    `PPMP_ASSERT_RST(a_result_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind planar_pixel_mask_plotter_core ppmp_checker u_ppmp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: sim/planar_pixel_mask_plotter_core_test.sv
// ----------------------------------------------------------------------------
// Planar pixel mask plotter core testbench
// Drives plot, read, clear and unused-action items into the core under
// several register settings and handshake gap patterns. A behavioral copy
// of the store, or a fixed row, sets each reply; fields checked in order.
// ----------------------------------------------------------------------------
module planar_pixel_mask_plotter_core_test;
    import ppmp_pkg::*;

    localparam int SCR_W = DEF_SCREEN_WIDTH;
    localparam int SCR_H = DEF_SCREEN_HEIGHT;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int NUM_PHASES = 8;
    localparam int PHASE_ITEMS = 50;
    localparam int LONG_HOLD = 300;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam logic [PATTERN_W-1:0] PAT_BAD_LO = 2'd2;
    localparam logic [PATTERN_W-1:0] PAT_BAD_HI = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PIX_W-1:0]    value;
    } reply_t;

    typedef struct packed {
        logic [ACTION_W-1:0]  act;
        logic [COORD_W-1:0]   x;
        logic [COORD_W-1:0]   y;
        logic [PATTERN_W-1:0] pat;
        logic                 fixed;
        logic [STATUS_W-1:0]  status;
        logic [PIX_W-1:0]     value;
    } directed_row_t;

    localparam int NUM_DIRECTED = 24;
    localparam directed_row_t DIRECTED [0:NUM_DIRECTED-1] = '{
        '{ACT_READ,   -512,    0, PAT_SINGLE, 1'b1, STATUS_REJECTED, 4'd0},
        '{ACT_PLOT,      0,    5, PAT_BAD_LO, 1'b1, STATUS_REJECTED, 4'd0},
        '{ACT_PLOT,      0,    5, PAT_BAD_HI, 1'b1, STATUS_REJECTED, 4'd0},
        '{ACT_UNUSED,    3,    3, PAT_SINGLE, 1'b1, STATUS_REJECTED, 4'd0},
        '{ACT_PLOT,    320,    5, PAT_SINGLE, 1'b1, STATUS_REJECTED, 4'd0},
        '{ACT_PLOT,     -1,    5, PAT_SINGLE, 1'b1, STATUS_REJECTED, 4'd0},
        '{ACT_PLOT,      5,  200, PAT_SINGLE, 1'b1, STATUS_REJECTED, 4'd0},
        '{ACT_PLOT,      5,  199, PAT_PAIR,   1'b1, STATUS_REJECTED, 4'd0},
        '{ACT_PLOT,      5,    0, PAT_SINGLE, 1'b1, STATUS_SKIPPED,  4'd0},
        '{ACT_PLOT,      0, -512, PAT_PAIR,   1'b1, STATUS_SKIPPED,  4'd0},
        '{ACT_READ,    511,  511, PAT_SINGLE, 1'b1, STATUS_REJECTED, 4'd0},
        '{ACT_READ,      0,  -1,  PAT_SINGLE, 1'b1, STATUS_REJECTED, 4'd0},
        '{ACT_CLEAR,     0,    0, PAT_SINGLE, 1'b1, STATUS_DONE,     4'd0},
        '{ACT_READ,      0,    0, PAT_SINGLE, 1'b1, STATUS_DONE,     4'd0},
        '{ACT_READ,    319,  199, PAT_SINGLE, 1'b1, STATUS_DONE,     4'd0},
        '{ACT_PLOT,    319,  199, PAT_SINGLE, 1'b0, STATUS_DONE,     4'd0},
        '{ACT_PLOT,     16,    1, PAT_PAIR,   1'b0, STATUS_DONE,     4'd0},
        '{ACT_PLOT,     17,    1, PAT_PAIR,   1'b0, STATUS_DONE,     4'd0},
        '{ACT_PLOT,      0,  198, PAT_PAIR,   1'b0, STATUS_DONE,     4'd0},
        '{ACT_PLOT,    319,   10, PAT_PAIR,   1'b0, STATUS_DONE,     4'd0},
        '{ACT_READ,     16,    2, PAT_SINGLE, 1'b0, STATUS_DONE,     4'd0},
        '{ACT_READ,    318,   11, PAT_SINGLE, 1'b0, STATUS_DONE,     4'd0},
        '{ACT_PLOT,    511,  511, PAT_BAD_HI, 1'b1, STATUS_REJECTED, 4'd0},
        '{ACT_READ,      1,  199, PAT_SINGLE, 1'b0, STATUS_DONE,     4'd0}
    };

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr = CFG_DRAW_MODE;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [ACTION_W-1:0]   s_tuser = ACT_PLOT;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [STATUS_W-1:0]   m_tuser;

    planar_pixel_mask_plotter_core #(
        .SCREEN_WIDTH  (SCR_W),
        .SCREEN_HEIGHT (SCR_H)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    logic [PIX_W-1:0] canvas [0:SCR_W*SCR_H-1];
    logic [PIX_W-1:0] cfg_mode = 4'd0;
    logic [PIX_W-1:0] cfg_planes = 4'd15;
    logic [PIX_W-1:0] cfg_xmask = 4'd0;
    logic             cfg_xon = 1'b0;

    reply_t expected_replies [$];
    reply_t head_reply;

    int error_count = 0;
    int reply_count = 0;
    int cycle_count = 0;
    int plot_items = 0;
    int read_items = 0;
    int clear_items = 0;
    int other_items = 0;
    int clears_left = 2;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_req_count = 0;
    int hold_ack_count = 0;
    int hold_left = 0;

    initial begin
        forever #2 aclk = ~aclk;
    end

    task automatic report_error(input string msg);
        $display("ERROR at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    task automatic paint_pixel(input int col, input int row, input bit do_xor,
                               input logic [PIX_W-1:0] xv, input logic [PIX_W-1:0] tgt);
        int idx;
        if (col >= 0 && col < SCR_W && row >= 0 && row < SCR_H) begin
            idx = row * SCR_W + col;
            if (do_xor) begin
                canvas[idx] = canvas[idx] ^ xv;
            end else begin
                canvas[idx] = (canvas[idx] & ~cfg_planes) | (tgt & cfg_planes);
            end
        end
    endtask

    task automatic predict_pixel_op(input logic [ACTION_W-1:0] act,
                                    input logic signed [COORD_W-1:0] xs,
                                    input logic signed [COORD_W-1:0] ys,
                                    input logic [PATTERN_W-1:0] pat,
                                    output reply_t rep);
        int x;
        int y;
        int rows;
        int c0;
        int c1;
        bit two;
        bit all_xor;
        logic [PIX_W-1:0] tgt;
        x = int'(xs);
        y = int'(ys);
        rep.status = STATUS_DONE;
        rep.value = '0;
        if (act == ACT_CLEAR) begin
            for (int i = 0; i < SCR_W * SCR_H; i++) canvas[i] = '0;
        end else if (act == ACT_READ) begin
            if (x < 0 || x >= SCR_W || y < 0 || y >= SCR_H) begin
                rep.status = STATUS_REJECTED;
            end else begin
                rep.value = canvas[y * SCR_W + x];
            end
        end else if (act == ACT_PLOT) begin
            rows = (pat == PAT_PAIR) ? 2 : 1;
            if (pat > PAT_PAIR || x < 0 || x >= SCR_W || y >= SCR_H || y + rows > SCR_H) begin
                rep.status = STATUS_REJECTED;
            end else if (y <= 0) begin
                rep.status = STATUS_SKIPPED;
            end else begin
                two = (pat == PAT_PAIR);
                if (!two) begin
                    c0 = x;
                    c1 = x;
                end else if (x % 16 == 0) begin
                    c0 = x;
                    c1 = x + 1;
                end else begin
                    c0 = x - 1;
                    c1 = x;
                end
                if (cfg_xon && cfg_xmask != 0) begin
                    paint_pixel(c0, y, 1'b1, cfg_xmask & cfg_planes, '0);
                    if (two) paint_pixel(c1, y, 1'b1, cfg_xmask & cfg_planes, '0);
                end else begin
                    all_xor = !two && cfg_mode == XOR_MODE;
                    tgt = (!two && cfg_mode > XOR_MODE) ? cfg_mode - 4'd1 : cfg_mode;
                    for (int r = y; r < y + rows; r++) begin
                        paint_pixel(c0, r, all_xor, cfg_planes, tgt);
                        if (two) paint_pixel(c1, r, all_xor, cfg_planes, tgt);
                    end
                end
            end
        end else begin
            rep.status = STATUS_REJECTED;
        end
    endtask

    task automatic push_item(input logic [ACTION_W-1:0] act, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y, input logic [PATTERN_W-1:0] pat,
                             input bit fixed, input reply_t fixed_rep);
        reply_t rep;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, pat, y, x};
        s_tuser <= act;
        do @(posedge aclk); while (!s_tready);
        predict_pixel_op(act, x, y, pat, rep);
        expected_replies.push_back(fixed ? fixed_rep : rep);
        case (act)
            ACT_PLOT:  plot_items++;
            ACT_READ:  read_items++;
            ACT_CLEAR: clear_items++;
            default:   other_items++;
        endcase
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_registers(input logic [3:0] mode, input logic [3:0] planes,
                                   input logic [3:0] xmask, input logic xon);
        cfg_wr_en <= 1'b1;
        cfg_addr <= CFG_DRAW_MODE;
        cfg_wdata <= mode;
        @(posedge aclk);
        cfg_addr <= CFG_PLANE_ENABLE;
        cfg_wdata <= planes;
        @(posedge aclk);
        cfg_addr <= CFG_XOR_MASK;
        cfg_wdata <= xmask;
        @(posedge aclk);
        cfg_addr <= CFG_XOR_ON;
        cfg_wdata <= {3'b000, xon};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_mode = mode;
        cfg_planes = planes;
        cfg_xmask = xmask;
        cfg_xon = xon;
    endtask

    task automatic random_item(output logic [ACTION_W-1:0] act, output logic [COORD_W-1:0] x,
                               output logic [COORD_W-1:0] y, output logic [PATTERN_W-1:0] pat);
        int area;
        int pick;
        area = $urandom_range(9);
        pick = $urandom_range(99);
        if (area < 6) begin
            x = COORD_W'($urandom_range(47));
            y = COORD_W'($urandom_range(9));
        end else if (area < 8) begin
            x = COORD_W'($urandom_range(SCR_W - 1, SCR_W - 48));
            y = COORD_W'($urandom_range(SCR_H - 1, SCR_H - 12));
        end else begin
            x = COORD_W'($urandom);
            y = COORD_W'($urandom);
        end
        pat = PATTERN_W'($urandom_range(1));
        if (clears_left > 0 && $urandom_range(249) == 0) begin
            act = ACT_CLEAR;
            clears_left--;
        end else if (pick < 55) begin
            act = ACT_PLOT;
        end else if (pick < 90) begin
            act = ACT_READ;
        end else if (pick < 96) begin
            act = ACT_PLOT;
            pat = PATTERN_W'($urandom_range(3, 2));
        end else begin
            act = ACT_UNUSED;
            pat = PATTERN_W'($urandom_range(3));
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            reply_count++;
            if (expected_replies.size() == 0) begin
                report_error($sformatf("reply with status %0d and no item pending", m_tuser));
            end else begin
                head_reply = expected_replies.pop_front();
                if (m_tuser !== head_reply.status) begin
                    report_error($sformatf("reply %0d status %0d, expected %0d",
                                           reply_count, m_tuser, head_reply.status));
                end
                if (m_tdata[PIX_W-1:0] !== head_reply.value) begin
                    report_error($sformatf("reply %0d pixel value %0d, expected %0d",
                                           reply_count, m_tdata[PIX_W-1:0], head_reply.value));
                end
            end
        end
        if (hold_req_count != hold_ack_count) begin
            hold_ack_count = hold_req_count;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Run stopped after %0d cycles with %0d replies outstanding.",
                 cycle_count, expected_replies.size());
        $display("FAILURE");
        $finish;
    end

    initial begin
        logic [ACTION_W-1:0]  act;
        logic [COORD_W-1:0]   x;
        logic [COORD_W-1:0]   y;
        logic [PATTERN_W-1:0] pat;
        logic [3:0]           mode;
        logic [3:0]           planes;
        logic [3:0]           xmask;
        logic                 xon;
        reply_t               fixed_rep;
        for (int i = 0; i < SCR_W * SCR_H; i++) canvas[i] = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < NUM_DIRECTED; i++) begin
            fixed_rep.status = DIRECTED[i].status;
            fixed_rep.value = DIRECTED[i].value;
            push_item(DIRECTED[i].act, DIRECTED[i].x, DIRECTED[i].y, DIRECTED[i].pat,
                      DIRECTED[i].fixed, fixed_rep);
        end
        fixed_rep = '0;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drained();
            case (ph)
                0: begin mode = 4'd0;  planes = 4'd0;  xmask = 4'd0;  xon = 1'b0; end
                1: begin mode = 4'd15; planes = 4'd15; xmask = 4'd15; xon = 1'b1; end
                2: begin mode = 4'd1;  planes = 4'd15; xmask = 4'd0;  xon = 1'b0; end
                3: begin mode = 4'd1;  planes = 4'd5;  xmask = 4'd0;  xon = 1'b1; end
                4: begin mode = 4'd7;  planes = 4'd10; xmask = 4'd6;  xon = 1'b1; end
                5: begin mode = 4'd2;  planes = 4'd15; xmask = 4'd9;  xon = 1'b0; end
                default: begin
                    mode = 4'($urandom_range(15));
                    planes = 4'($urandom_range(15));
                    xmask = 4'($urandom_range(15));
                    xon = 1'($urandom_range(1));
                end
            endcase
            write_registers(mode, planes, xmask, xon);
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct <= 0;  end
                1: begin send_idle_pct = 51; stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  stall_pct <= 51; end
                default: begin send_idle_pct = 20; stall_pct <= 20; end
            endcase
            if (ph == 2) hold_req_count <= hold_req_count + 1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                random_item(act, x, y, pat);
                push_item(act, x, y, pat, 1'b0, fixed_rep);
            end
        end

        wait_drained();
        repeat (20) @(posedge aclk);
        $display("Covered %0d plots, %0d reads, %0d clears and %0d unused actions;",
                 plot_items, read_items, clear_items, other_items);
        $display("%0d replies compared across %0d register settings and four gap patterns.",
                 reply_count, NUM_PHASES);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
